>>> sv/pic_pkg.sv
// shared types and constants of the interrupt controller register block
`default_nettype none
package pic_pkg;

    // operation codes of a request item
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_LINE  = 2'd2;

    // decoded bus ports
    localparam logic [7:0] PORT_CMD    = 8'h20;
    localparam logic [7:0] PORT_DATA   = 8'h21;
    localparam logic [7:0] PORT_VECTOR = 8'hA0;

    // command word bits
    localparam logic [7:0] ICW1_FLAG = 8'h10;
    localparam logic [7:0] OCW_KIND  = 8'h18;
    localparam logic [7:0] OCW3_KIND = 8'h08;
    localparam logic [7:0] BIT0      = 8'h01;

    // initialization phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_ICW2   = 3'd1;
    localparam logic [2:0] PH_ICW3   = 3'd2;
    localparam logic [2:0] PH_ICW4   = 3'd3;
    localparam logic [2:0] PH_NORMAL = 3'd4;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] port;
        logic [7:0] write_data;
        logic [2:0] line_number;
        logic       line_active;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_out;
    } t_rsp;

endpackage
`default_nettype wire

>>> sv/pic_if.sv
// valid/ready channel interfaces for request and response items
`default_nettype none
interface pic_req_if;
    logic              valid;
    logic              ready;
    pic_pkg::t_req     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pic_rsp_if;
    logic              valid;
    logic              ready;
    pic_pkg::t_rsp     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/pic_in_stage.sv
// input register stage holding one request item
`default_nettype none
module pic_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    pic_req_if.sink            i_req,
    input  wire logic          i_advance,
    output logic               o_valid,
    output pic_pkg::t_req      o_item
);
    logic          r_valid;
    pic_pkg::t_req r_item;

    // free slot, or the held item leaves this cycle
    assign i_req.ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_item <= i_req.data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule
`default_nettype wire

>>> sv/pic_core.sv
// controller state registers and their one-pass update per item
`default_nettype none
module pic_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire pic_pkg::t_req i_item,
    output pic_pkg::t_rsp      o_rsp
);
    logic [7:0] r_in_service, n_in_service;
    logic [7:0] r_request,    n_request;
    logic [7:0] r_mask,       n_mask;
    logic [7:0] r_vector,     n_vector;
    logic [2:0] r_phase,      n_phase;
    logic       r_fourth,     n_fourth;
    logic [7:0] r_read_sel,   n_read_sel;
    logic       r_irq,        n_irq;
    logic [7:0] rd;
    logic [7:0] line_bit;

    assign line_bit = 8'b1 << i_item.line_number;

    always_comb begin
        n_in_service = r_in_service;
        n_request    = r_request;
        n_mask       = r_mask;
        n_vector     = r_vector;
        n_phase      = r_phase;
        n_fourth     = r_fourth;
        n_read_sel   = r_read_sel;
        n_irq        = r_irq;
        rd           = 8'd0;
        case (i_item.operation)
            pic_pkg::OP_WRITE: begin
                if (i_item.port == pic_pkg::PORT_VECTOR) begin
                    n_vector = i_item.write_data;
                end else if (i_item.port == pic_pkg::PORT_CMD
                             && (i_item.write_data & pic_pkg::ICW1_FLAG) != 8'd0) begin
                    n_fourth = i_item.write_data[0];
                    n_phase  = pic_pkg::PH_ICW2;
                end else if (i_item.port == pic_pkg::PORT_CMD
                             || i_item.port == pic_pkg::PORT_DATA) begin
                    case (r_phase)
                        pic_pkg::PH_ICW2:
                            n_phase = r_fourth ? pic_pkg::PH_ICW4 : pic_pkg::PH_ICW3;
                        pic_pkg::PH_ICW3:
                            n_phase = pic_pkg::PH_IDLE;
                        pic_pkg::PH_ICW4:
                            n_phase = pic_pkg::PH_NORMAL;
                        pic_pkg::PH_NORMAL: begin
                            if (i_item.port == pic_pkg::PORT_DATA) begin
                                n_mask = i_item.write_data;
                            end else if ((i_item.write_data & pic_pkg::OCW_KIND)
                                         == pic_pkg::OCW3_KIND) begin
                                n_read_sel = i_item.write_data;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            pic_pkg::OP_READ: begin
                if (i_item.port == pic_pkg::PORT_VECTOR) begin
                    rd    = r_vector;
                    n_irq = 1'b0;
                end else if (i_item.port == pic_pkg::PORT_CMD) begin
                    rd = ((r_read_sel & pic_pkg::BIT0) != 8'd0) ? r_request : r_in_service;
                end else if (i_item.port == pic_pkg::PORT_DATA) begin
                    rd = r_mask;
                end
            end
            pic_pkg::OP_LINE: begin
                if (!i_item.line_active) begin
                    n_vector     = 8'd0;
                    n_in_service = r_in_service & ~line_bit;
                    n_request    = r_request & ~line_bit;
                    n_irq        = 1'b0;
                end else begin
                    n_vector  = {5'd0, i_item.line_number};
                    n_request = r_request | line_bit;
                    if ((r_mask & line_bit) == 8'd0 && r_in_service == 8'd0) begin
                        n_in_service = r_in_service | line_bit;
                        n_irq        = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_service <= 8'd0;
            r_request    <= 8'd0;
            r_mask       <= 8'd0;
            r_vector     <= 8'd0;
            r_phase      <= pic_pkg::PH_IDLE;
            r_fourth     <= 1'b0;
            r_read_sel   <= 8'd0;
            r_irq        <= 1'b0;
        end else if (i_fire) begin
            r_in_service <= n_in_service;
            r_request    <= n_request;
            r_mask       <= n_mask;
            r_vector     <= n_vector;
            r_phase      <= n_phase;
            r_fourth     <= n_fourth;
            r_read_sel   <= n_read_sel;
            r_irq        <= n_irq;
        end
    end

    assign o_rsp.read_data = rd;
    assign o_rsp.irq_out   = n_irq;
endmodule
`default_nettype wire

>>> sv/interrupt_controller_regs.sv
// top level of the 8259-style interrupt controller register block
//
//  channel  dir  modport  payload
//  i_req    in   sink     operation, port, write_data, line_number, line_active
//  o_rsp    out  source   read_data, irq_out
//
// one item per cycle sustained while results are taken; an item passes through the input
// register, then the result register, and its result is offered from the result register
// until taken, the state updating as the item leaves the input register
// synchronous active-low reset clears the controller state and both valid flags
// a stalled result holds in the result register; the input register still takes
// an item and only stalls once both registers are full
`default_nettype none
module interrupt_controller_regs (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pic_req_if.sink   i_req,
    pic_rsp_if.source o_rsp
);
    logic          in_valid;
    pic_pkg::t_req in_item;
    pic_pkg::t_rsp core_rsp;
    logic          advance;
    logic          r_out_valid;
    pic_pkg::t_rsp r_out;

    // item moves on when the result register is free or being drained
    assign advance = in_valid && (!r_out_valid || o_rsp.ready);

    pic_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    // state and decode, updated once per advancing item
    pic_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (advance),
        .i_item  (in_item),
        .o_rsp   (core_rsp)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out <= core_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
endmodule
`default_nettype wire

>>> sim/pic_checker.sv
// checker for the interrupt controller: predicts each result and compares it with the one returned
`timescale 1ns / 100ps
module pic_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pic_req_if        i_req,
    pic_rsp_if        i_rsp,
    output int        o_fail_count,
    output int        o_awaited
);
    import pic_pkg::*;

    // predicted controller state
    logic [7:0] in_service;
    logic [7:0] request_bits;
    logic [7:0] mask_bits;
    logic [7:0] last_vector;
    logic [7:0] read_select;
    logic [2:0] init_phase;
    logic       fourth_word;
    logic       irq_level;

    t_rsp awaited_rsp[$];

    initial begin
        o_fail_count = 0;
        o_awaited    = 0;
    end

    // applies one item to the predicted state, returns the result it should give
    function automatic t_rsp pic_advance(input t_req r);
        t_rsp       rsp;
        logic [7:0] line_bit;
        rsp.read_data = '0;
        line_bit = 8'b1 << r.line_number;
        case (r.operation)
            OP_WRITE: begin
                if (r.port == PORT_VECTOR) begin
                    last_vector = r.write_data;
                end else if (r.port == PORT_CMD && (r.write_data & ICW1_FLAG) != 8'h00) begin
                    fourth_word = r.write_data[0];
                    init_phase  = PH_ICW2;
                end else if (r.port == PORT_CMD || r.port == PORT_DATA) begin
                    case (init_phase)
                        PH_ICW2:   init_phase = fourth_word ? PH_ICW4 : PH_ICW3;
                        PH_ICW3:   init_phase = PH_IDLE;
                        PH_ICW4:   init_phase = PH_NORMAL;
                        PH_NORMAL: begin
                            if (r.port == PORT_DATA) begin
                                mask_bits = r.write_data;
                            end else if ((r.write_data & OCW_KIND) == OCW3_KIND) begin
                                read_select = r.write_data;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            OP_READ: begin
                if (r.port == PORT_VECTOR) begin
                    rsp.read_data = last_vector;
                    irq_level     = 1'b0;
                end else if (r.port == PORT_CMD) begin
                    rsp.read_data = ((read_select & BIT0) != 8'h00) ? request_bits : in_service;
                end else if (r.port == PORT_DATA) begin
                    rsp.read_data = mask_bits;
                end
            end
            OP_LINE: begin
                if (!r.line_active) begin
                    last_vector  = '0;
                    in_service   = in_service & ~line_bit;
                    request_bits = request_bits & ~line_bit;
                    irq_level    = 1'b0;
                end else begin
                    last_vector  = {5'b0, r.line_number};
                    request_bits = request_bits | line_bit;
                    if ((mask_bits & line_bit) == 8'h00 && in_service == 8'h00) begin
                        in_service = in_service | line_bit;
                        irq_level  = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        rsp.irq_out = irq_level;
        return rsp;
    endfunction

    task automatic report(input string what, input int want, input int got);
        if (o_fail_count < 10) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
        end
        o_fail_count = o_fail_count + 1;
    endtask

    always @(posedge i_clk) begin : watch
        t_rsp want;
        if (!i_rst_n) begin
            in_service   = '0;
            request_bits = '0;
            mask_bits    = '0;
            last_vector  = '0;
            read_select  = '0;
            init_phase   = PH_IDLE;
            fourth_word  = 1'b0;
            irq_level    = 1'b0;
            awaited_rsp.delete();
        end else begin
            // results first: an item taken at this edge cannot have its result yet
            if (i_rsp.valid && i_rsp.ready) begin
                if (awaited_rsp.size() == 0) begin
                    report("unexpected result, read_data", 0, int'(i_rsp.data.read_data));
                end else begin
                    want = awaited_rsp.pop_front();
                    if (want.read_data !== i_rsp.data.read_data) begin
                        report("read_data", int'(want.read_data),
                               int'(i_rsp.data.read_data));
                    end
                    if (want.irq_out !== i_rsp.data.irq_out) begin
                        report("irq_out", int'(want.irq_out), int'(i_rsp.data.irq_out));
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                awaited_rsp.push_back(pic_advance(i_req.data));
            end
        end
        o_awaited = awaited_rsp.size();
    end

endmodule

>>> sim/tb_interrupt_controller_regs.sv
// testbench top of the interrupt controller: stimulus, idling and verdict
`timescale 1ns / 100ps
module tb_interrupt_controller_regs;
    import pic_pkg::*;

    localparam int RANDOM_ITEMS = 500;
    localparam int CYCLE_LIMIT  = 200000;   // far beyond the slowest correct run

    logic clk;
    logic rst_n;
    logic no_idle;      // when high neither side idles
    int   fail_count;
    int   awaited;      // results still owed by the block
    int   items_sent;

    pic_req_if req_ch();
    pic_rsp_if rsp_ch();

    interrupt_controller_regs dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    pic_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_awaited    (awaited)
    );

    always #4 clk = ~clk;

    // receiver stalls at random, except within the steady stretch
    always @(negedge clk) begin
        rsp_ch.ready <= no_idle || ($urandom_range(0, 99) >= 27);
    end

    // watchdog: a hung block ends the run here
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_interrupt_controller_regs NOT OK");
        $finish;
    end

    // presents one item from a falling edge and holds it until the block takes it;
    // returns at the falling edge after acceptance
    task automatic send_item(input logic [1:0] op, input logic [7:0] port,
                             input logic [7:0] wdata, input logic [2:0] line_no,
                             input logic line_on);
        t_req r;
        r.operation   = op;
        r.port        = port;
        r.write_data  = wdata;
        r.line_number = line_no;
        r.line_active = line_on;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 27) begin
                req_ch.valid <= 1'b0;
                @(negedge clk);
            end
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // holds the sender back until every result owed has come out
    task automatic drain;
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (awaited != 0) @(negedge clk);
    endtask

    // short-hand for a bus access with random line fields
    task automatic bus_item(input logic [1:0] op, input logic [7:0] port,
                            input logic [7:0] wdata);
        send_item(op, port, wdata, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
    endtask

    initial begin : stimulus
        int         pick;
        logic [7:0] word;
        logic [7:0] port;
        clk          = 1'b0;
        rst_n        = 1'b0;
        no_idle      = 1'b0;
        items_sent   = 0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;

        // single reset at the start
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // directed: state straight after reset
        send_item(OP_READ, PORT_CMD, 8'h00, 3'd0, 1'b0);
        send_item(OP_READ, PORT_DATA, 8'h00, 3'd0, 1'b0);
        send_item(OP_READ, PORT_VECTOR, 8'h00, 3'd0, 1'b0);
        // mask write ignored before initialisation
        send_item(OP_WRITE, PORT_DATA, 8'hFF, 3'd0, 1'b0);
        send_item(OP_READ, PORT_DATA, 8'h00, 3'd0, 1'b0);
        // init without a fourth word: third word sends it back to idle
        send_item(OP_WRITE, PORT_CMD, 8'h10, 3'd0, 1'b0);
        send_item(OP_WRITE, PORT_DATA, 8'h08, 3'd0, 1'b0);
        send_item(OP_WRITE, PORT_DATA, 8'h04, 3'd0, 1'b0);
        send_item(OP_WRITE, PORT_DATA, 8'h55, 3'd0, 1'b0);
        send_item(OP_READ, PORT_DATA, 8'h00, 3'd0, 1'b0);
        // full init with fourth word into normal mode
        send_item(OP_WRITE, PORT_CMD, 8'hFF, 3'd0, 1'b0);
        send_item(OP_WRITE, PORT_DATA, 8'h20, 3'd0, 1'b0);
        send_item(OP_WRITE, PORT_DATA, 8'h01, 3'd0, 1'b0);
        send_item(OP_WRITE, PORT_DATA, 8'h00, 3'd0, 1'b0);
        // highest line raises the output; in-service then request register read back
        send_item(OP_LINE, 8'h00, 8'h00, 3'd7, 1'b1);
        send_item(OP_READ, PORT_CMD, 8'h00, 3'd0, 1'b0);
        send_item(OP_WRITE, PORT_CMD, 8'h0B, 3'd0, 1'b0);
        send_item(OP_LINE, 8'hFF, 8'hFF, 3'd3, 1'b1);
        send_item(OP_READ, PORT_CMD, 8'h00, 3'd0, 1'b0);
        // non-OCW3 command ignored, vector read drops the output
        send_item(OP_WRITE, PORT_CMD, 8'h20, 3'd0, 1'b0);
        send_item(OP_READ, PORT_VECTOR, 8'h00, 3'd0, 1'b0);
        send_item(OP_LINE, 8'h00, 8'h00, 3'd7, 1'b0);
        send_item(OP_WRITE, PORT_VECTOR, 8'hFF, 3'd0, 1'b0);
        send_item(OP_READ, PORT_VECTOR, 8'h00, 3'd0, 1'b0);
        // fully masked line, unknown operation, undecoded ports
        send_item(OP_WRITE, PORT_DATA, 8'hFF, 3'd0, 1'b0);
        send_item(OP_LINE, 8'h00, 8'h00, 3'd0, 1'b1);
        send_item(2'd3, PORT_CMD, 8'h10, 3'd5, 1'b1);
        send_item(OP_READ, 8'h55, 8'h00, 3'd0, 1'b0);
        send_item(OP_WRITE, 8'h00, 8'hAA, 3'd0, 1'b0);
        drain();

        // random part: mostly well-formed traffic after a fresh init, some noise
        items_sent = 0;
        bus_item(OP_WRITE, PORT_CMD, 8'h11);
        bus_item(OP_WRITE, PORT_DATA, 8'h08);
        bus_item(OP_WRITE, PORT_DATA, 8'h01);
        while (items_sent < RANDOM_ITEMS) begin
            // a steady stretch with no idling on either side
            no_idle <= (items_sent >= 150 && items_sent < 260);
            if (items_sent % 120 == 119) drain();
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                // init sequence, with or without fourth word
                word = 8'($urandom) | ICW1_FLAG;
                bus_item(OP_WRITE, PORT_CMD, word);
                port = $urandom_range(0, 1) ? PORT_DATA : PORT_CMD;
                bus_item(OP_WRITE, port, 8'($urandom) & ~ICW1_FLAG);
                bus_item(OP_WRITE, PORT_DATA, 8'($urandom));
            end else if (pick < 16) begin
                // mask, usually sparse so lines get through
                word = 8'($urandom) & 8'($urandom) & 8'($urandom);
                if ($urandom_range(0, 3) == 0) word = 8'($urandom);
                bus_item(OP_WRITE, PORT_DATA, word);
            end else if (pick < 24) begin
                word = (8'($urandom) & ~OCW_KIND) | OCW3_KIND;
                bus_item(OP_WRITE, PORT_CMD, word);
            end else if (pick < 28) begin
                bus_item(OP_WRITE, PORT_CMD, 8'($urandom));
            end else if (pick < 45) begin
                case ($urandom_range(0, 3))
                    0:       port = PORT_CMD;
                    1:       port = PORT_DATA;
                    2:       port = PORT_VECTOR;
                    default: port = 8'($urandom);
                endcase
                bus_item(OP_READ, port, 8'($urandom));
            end else if (pick < 50) begin
                bus_item(OP_WRITE, PORT_VECTOR, 8'($urandom));
            end else if (pick < 86) begin
                send_item(OP_LINE, 8'($urandom), 8'($urandom), 3'($urandom_range(0, 7)),
                          $urandom_range(0, 9) < 6);
            end else begin
                // noise over every field, unknown operation code included
                send_item(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                          3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            end
        end

        // end of run: wait for the last results, then stay quiet before the verdict
        no_idle <= 1'b0;
        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0) begin
            $display("tb_interrupt_controller_regs OK");
        end else begin
            $display("tb_interrupt_controller_regs NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
sv/pic_pkg.sv
sv/pic_if.sv
sv/pic_in_stage.sv
sv/pic_core.sv
sv/interrupt_controller_regs.sv
sim/pic_checker.sv
sim/tb_interrupt_controller_regs.sv
